FILE: hdl/st5_pkg.sv
// ----------------------------------------------------------------------------
// st5_pkg
// Shared constants and helpers for the top-K score selector.
// ----------------------------------------------------------------------------
package st5_pkg;

  localparam int TOP_COUNT_DEF   = 5;
  localparam int INDEX_WIDTH_DEF = 16;
  localparam int SCORE_W         = 32;
  localparam int RANK_W          = 3;
  localparam int CLASS_W         = 16;

  localparam logic FMT_FP32 = 1'b0;
  localparam logic FMT_FP16 = 1'b1;

  // Exact FP16 to FP32 widening.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] sign;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  lz;
    logic [10:0] norm;
    logic [7:0]  e32;
    sign = {h[15], 31'd0};
    ex   = h[14:10];
    man  = h[9:0];
    lz   = 4'd0;
    for (int i = 9; i >= 0; i--) begin
      if (man[i] && lz == 4'd0) begin
        lz = 4'(10 - i);
      end
    end
    norm = {1'b0, man} << lz;
    e32  = 8'(8'd113 - {4'd0, lz});
    if (ex == 5'd0) begin
      if (man == 10'd0) begin
        half_to_single = sign;
      end else begin
        half_to_single = sign | {1'b0, e32, norm[9:0], 13'd0};
      end
    end else if (ex == 5'h1f) begin
      half_to_single = sign | 32'h7F80_0000 | {9'd0, man, 13'd0};
    end else begin
      half_to_single = sign | {1'b0, 8'({3'd0, ex} + 8'd112), man, 13'd0};
    end
  endfunction

  // Monotone unsigned key; both zeros map alike.
  function automatic logic [31:0] order_key(input logic [31:0] f);
    if (f[30:0] == 31'd0) begin
      order_key = 32'h8000_0000;
    end else if (f[31]) begin
      order_key = ~f;
    end else begin
      order_key = f | 32'h8000_0000;
    end
  endfunction

  function automatic logic is_nan(input logic [31:0] f);
    is_nan = (f[30:23] == 8'hff) && (f[22:0] != 23'd0);
  endfunction

endpackage

FILE: hdl/st5_stream_if.sv
// ----------------------------------------------------------------------------
// st5_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface st5_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/st5_cell.sv
// ----------------------------------------------------------------------------
// st5_cell
// One slot of the sorted chain: compares the passing key with its own entry
// and either keeps, replaces, or shifts in from the left neighbor.
// ----------------------------------------------------------------------------
module st5_cell #(
  parameter int INDEX_WIDTH = st5_pkg::INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic                   clear,
  input  logic [31:0]            new_score,
  input  logic [31:0]            new_key,
  input  logic [INDEX_WIDTH-1:0] new_index,
  input  logic                   left_valid,
  input  logic                   left_ins,
  input  logic [31:0]            left_score,
  input  logic [INDEX_WIDTH-1:0] left_index,
  input  logic                   left_hit,
  output logic                   own_valid,
  output logic                   own_ins,
  output logic                   own_hit,
  output logic [31:0]            score,
  output logic [INDEX_WIDTH-1:0] index
);
  logic        gt;
  logic        eq;
  logic [31:0] own_key;

  assign own_key = st5_pkg::order_key(score);
  assign eq      = own_valid && (own_key == new_key);
  assign gt      = !own_valid || (new_key > own_key);
  // insertion point is here or further left; hit anywhere blocks insert
  assign own_ins = gt;
  assign own_hit = left_hit || eq;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      own_valid <= 1'b0;
    end else if (load && !own_hit && gt) begin
      own_valid <= left_ins ? left_valid : 1'b1;
    end
    if (load) begin
      if (eq) begin
        index <= new_index;
      end else if (!own_hit && gt) begin
        if (left_ins) begin
          score <= left_score;
          index <= left_index;
        end else begin
          score <= new_score;
          index <= new_index;
        end
      end
    end
  end
endmodule

FILE: hdl/score_top5_selector.sv
// ----------------------------------------------------------------------------
// score_top5_selector
// Streaming top-K selector for FP32/FP16 classifier scores.
// ----------------------------------------------------------------------------
// in  : request = {element_bits, last_element}; one request per cycle when ready.
// out : request = {rank, class_index, score_value, last_of_run}.
// The format register (cfg_we/cfg_wdata) picks FP32 words (0) or FP16 in bits 15..0 (1).
// Each request is inserted into a chain of TOP_COUNT sorted cells; the cells
// compare in parallel and shift right on insertion.
// On last_element the chain contents are copied to a drain bank, the chain
// clears, and ranked results leave one per cycle while the receiver is ready, largest first.
// Throughput: one request per cycle while in_ch.ready is high.
// A run's last request is accepted only while the drain bank is free, so a
// new last waits behind the previous drain, longer while the receiver stalls.
// The first result is valid in the cycle after the last request is accepted.
// Reset empties chain and drain bank and zeroes the position counter.
// A stalled receiver holds the current result; the input keeps flowing
// until a further last request needs the drain bank.
// ----------------------------------------------------------------------------
module score_top5_selector #(
  parameter int TOP_COUNT   = st5_pkg::TOP_COUNT_DEF,
  parameter int INDEX_WIDTH = st5_pkg::INDEX_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  st5_stream_if.sink   in_ch,
  st5_stream_if.source out_ch
);
  localparam int CW = $clog2(TOP_COUNT + 1);

  logic                   fmt;
  logic [INDEX_WIDTH-1:0] pos;
  logic [31:0]            f;
  logic [31:0]            k;
  logic                   acc;
  logic                   drain_busy;

  logic [TOP_COUNT:0]     vld_c, ins_c, hit_c;
  logic [31:0]            sc [TOP_COUNT+1];
  logic [INDEX_WIDTH-1:0] ix [TOP_COUNT+1];

  logic [31:0]            dsc [TOP_COUNT];
  logic [INDEX_WIDTH-1:0] dix [TOP_COUNT];
  logic [CW-1:0]          dcnt;
  logic [CW-1:0]          dptr;
  logic [CW-1:0]          cnt_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= st5_pkg::FMT_FP32;
    end else if (cfg_we) begin
      fmt <= cfg_wdata;
    end
  end

  assign f = (fmt == st5_pkg::FMT_FP16)
             ? st5_pkg::half_to_single(in_ch.payload.element_bits[15:0])
             : in_ch.payload.element_bits;
  assign k = st5_pkg::order_key(f);
  assign in_ch.ready = !(in_ch.payload.last_element && drain_busy);
  assign acc = in_ch.valid && in_ch.ready;

  assign vld_c[0] = 1'b1;
  assign ins_c[0] = 1'b0;
  assign hit_c[0] = 1'b0;
  assign sc[0]    = 32'd0;
  assign ix[0]    = '0;

  for (genvar g = 0; g < TOP_COUNT; g++) begin : g_cell
    st5_cell #(.INDEX_WIDTH(INDEX_WIDTH)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .load       (acc && !st5_pkg::is_nan(f)),
      .clear      (acc && in_ch.payload.last_element),
      .new_score  (f),
      .new_key    (k),
      .new_index  (pos),
      .left_valid (vld_c[g]),
      .left_ins   (ins_c[g]),
      .left_score (sc[g]),
      .left_index (ix[g]),
      .left_hit   (hit_c[g]),
      .own_valid  (vld_c[g+1]),
      .own_ins    (ins_c[g+1]),
      .own_hit    (hit_c[g+1]),
      .score      (sc[g+1]),
      .index      (ix[g+1])
    );
  end

  // chain state after this request, seen combinationally for the drain copy
  logic [31:0]            nsc [TOP_COUNT];
  logic [INDEX_WIDTH-1:0] nix [TOP_COUNT];
  logic [TOP_COUNT-1:0]   nvld;
  logic                   upd;
  assign upd = !st5_pkg::is_nan(f);

  always_comb begin
    for (int i = 0; i < TOP_COUNT; i++) begin
      nsc[i]  = sc[i+1];
      nix[i]  = ix[i+1];
      nvld[i] = vld_c[i+1];
      if (upd) begin
        if (vld_c[i+1] && st5_pkg::order_key(sc[i+1]) == k) begin
          nix[i] = pos;
        end else if (!hit_c[i+1] && ins_c[i+1]) begin
          if (ins_c[i]) begin
            nvld[i] = vld_c[i];
            nsc[i]  = sc[i];
            nix[i]  = ix[i];
          end else begin
            nvld[i] = 1'b1;
            nsc[i]  = f;
            nix[i]  = pos;
          end
        end
      end
    end
    cnt_now = '0;
    for (int i = 0; i < TOP_COUNT; i++) begin
      cnt_now = cnt_now + CW'(nvld[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      drain_busy <= 1'b0;
      dcnt       <= '0;
      dptr       <= '0;
    end else begin
      if (acc) begin
        if (in_ch.payload.last_element) begin
          pos <= '0;
          if (cnt_now != '0) begin
            drain_busy <= 1'b1;
            dcnt       <= cnt_now;
            dptr       <= '0;
          end
        end else begin
          pos <= pos + 1'b1;
        end
      end
      if (drain_busy && out_ch.ready) begin
        dptr <= dptr + 1'b1;
        if (dptr + 1'b1 == dcnt) begin
          drain_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_ch.payload.last_element) begin
      for (int i = 0; i < TOP_COUNT; i++) begin
        dsc[i] <= nsc[i];
        dix[i] <= nix[i];
      end
    end
  end

  assign out_ch.valid                = drain_busy;
  assign out_ch.payload.rank         = 3'(dptr + 1'b1);
  assign out_ch.payload.class_index  = 16'(dix[dptr[$clog2(TOP_COUNT > 1 ? TOP_COUNT : 2)-1:0]]);
  assign out_ch.payload.score_value  = dsc[dptr[$clog2(TOP_COUNT > 1 ? TOP_COUNT : 2)-1:0]];
  assign out_ch.payload.last_of_run  = (dptr + 1'b1 == dcnt);
endmodule
